// ===== sv/pmdbc_pkg.sv =====
// Shared types and constants of the page-mode display byte controller.
`default_nettype none

package pmdbc_pkg;

  // Fixed field and port widths
  localparam int DATA_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int RADDR_W     = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_BLOCK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_RES      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_DISP_ON  = 3'd4;

  // Command latch codes
  localparam logic [DATA_W-1:0] LATCH_ARMED = 8'hFF;
  localparam logic [DATA_W-1:0] CTRL_DATA   = 8'h40;
  localparam logic [DATA_W-1:0] CTRL_CMD    = 8'h00;

  // Argument positions within a command
  localparam logic [DATA_W-1:0] ARG_FIRST_COL  = 8'd1;
  localparam logic [DATA_W-1:0] ARG_LAST_COL   = 8'd2;
  localparam logic [DATA_W-1:0] ARG_START_PAGE = 8'd3;
  localparam logic [DATA_W-1:0] ARG_BLOCK_END  = 8'd4;
  localparam logic [DATA_W-1:0] ARG_MODE       = 8'd1;
  localparam logic [DATA_W-1:0] ARG_MODE_PAD   = 8'd2;
  localparam logic [DATA_W-1:0] ARG_WIDTH      = 8'd1;
  localparam logic [DATA_W-1:0] ARG_HEIGHT     = 8'd2;
  localparam logic [DATA_W-1:0] ARG_BPP        = 8'd3;

  // Item kinds carried on in_tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_BYTE  = 2'd1,
    FN_STOP  = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDCAP,
    ST_SCAT,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic [DATA_W-1:0] res_bpp;
    logic [DATA_W-1:0] res_height;
    logic [DATA_W-1:0] res_width;
    logic              display_enabled;
    logic [DATA_W-1:0] mode_value;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/page_mode_display_byte_controller.sv =====
// Top level of the page-mode display byte controller with its frame store.
`default_nettype none

// Takes start, stop, data-byte and read transactions one at a time and returns one result
// per transaction. After reset a clearing pass zeroes the frame store, one byte per cycle,
// with in_tready low; configuration writes are taken during the pass. Start, stop and
// command bytes then pass through ST_DONE, reads through ST_RDCAP and ST_DONE, and a
// pixel-data byte through ST_SCAT, ST_FLUSH and ST_DONE: its eight frame-store rows go
// through the single read port and single write port of the store, each row written back
// in the cycle after it is read while the following row is read. A finished result sits in
// the output register while the next transaction is accepted.
module page_mode_display_byte_controller #(
  parameter int ROW_BYTES = 16,
  parameter int ROWS      = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write port
  input  wire                                 cfg_we,
  input  wire  [pmdbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pmdbc_pkg::DATA_W-1:0]        cfg_wdata,
  // input channel
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [pmdbc_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_byte[7:0], read_addr[17:8]
  input  wire  [pmdbc_pkg::FUNC_W-1:0]        in_tuser,   // func[1:0]
  // result channel
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [pmdbc_pkg::OUT_TDATA_W-1:0]   out_tdata   // read_data[7:0], mode_value[15:8],
                                                          // display_enabled[16],
                                                          // res_width[24:17],
                                                          // res_height[32:25],
                                                          // res_bpp[40:33]
);
  import pmdbc_pkg::*;

  localparam int STORE_SIZE = ROW_BYTES * ROWS;
  localparam int MEM_AW     = $clog2(STORE_SIZE);
  localparam int CALC_W     = $clog2(1024 + 32 + 263 * ROW_BYTES);

  // configuration registers
  logic [DATA_W-1:0] panel_width_r, op_block_r, op_mode_r, op_res_r, op_disp_r;

  // controller state
  logic [DATA_W-1:0] latch_r, arg_r, first_col_r, last_col_r, col_r, row_r;
  logic [DATA_W-1:0] mode_r, width_r, height_r, bpp_r;
  logic              disp_r;
  logic [DATA_W-1:0] latch_nxt, arg_nxt, first_col_nxt, last_col_nxt, col_nxt, row_nxt;
  logic [DATA_W-1:0] mode_nxt, width_nxt, height_nxt, bpp_nxt;
  logic              disp_nxt, pixel_go;

  state_t state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r;

  // scatter and read datapath
  logic [CALC_W-1:0] scat_addr_r, wr_addr_r;
  logic [DATA_W-1:0] scat_bits_r, rdata_r, mem_rd_r;
  logic [2:0]        scat_col_r, scat_k_r;
  logic              wr_ok_r, wr_bit_r, rd_ok_r;

  logic [DATA_W-1:0] mem [STORE_SIZE];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd, bit_mask;

  logic              in_acc, done_load, clr_last;
  func_t             func;
  logic [DATA_W-1:0] d_byte;
  logic [CALC_W-1:0] raddr_ext, pix_base;
  result_t           res_w;
  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  function automatic logic [DATA_W-1:0] clamp_col(input logic [DATA_W-1:0] v,
                                                  input logic [DATA_W-1:0] pw);
    return (v >= pw) ? DATA_W'(pw - 8'd1) : v;
  endfunction

  assign func      = func_t'(in_tuser);
  assign d_byte    = in_tdata[7:0];
  assign raddr_ext = CALC_W'(in_tdata[17:8]);
  assign in_acc    = in_tvalid && in_tready;
  assign clr_last  = (clr_cnt_r == MEM_AW'(STORE_SIZE - 1));
  assign pix_base  = CALC_W'(col_r[7:3]) + CALC_W'(row_r) * CALC_W'(ROW_BYTES);

  // Decode one host byte against the command latch
  always_comb begin
    logic [DATA_W-1:0] lat_v, arg_v, col_inc;
    lat_v         = latch_r;
    arg_v         = arg_r;
    col_inc       = col_r + 8'd1;
    latch_nxt     = latch_r;
    arg_nxt       = arg_r;
    first_col_nxt = first_col_r;
    last_col_nxt  = last_col_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    mode_nxt      = mode_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    bpp_nxt       = bpp_r;
    disp_nxt      = disp_r;
    pixel_go      = 1'b0;
    if (latch_r == LATCH_ARMED) begin
      latch_nxt = d_byte;
    end else if (latch_r == CTRL_DATA) begin
      // pixel column: advance cursor, wrap within the window
      pixel_go = 1'b1;
      if (col_inc > last_col_r) begin
        col_nxt = first_col_r;
        row_nxt = row_r + 8'd8;
      end else begin
        col_nxt = col_inc;
      end
    end else begin
      if (lat_v == CTRL_CMD) begin
        lat_v = d_byte;
        arg_v = '0;
      end
      if (lat_v == op_block_r) begin
        if (arg_v == ARG_FIRST_COL) begin
          first_col_nxt = clamp_col(d_byte, panel_width_r);
          col_nxt       = clamp_col(d_byte, panel_width_r);
        end
        if (arg_v == ARG_LAST_COL)   last_col_nxt = clamp_col(d_byte, panel_width_r);
        if (arg_v == ARG_START_PAGE) row_nxt = {d_byte[4:0], 3'b000};
        if (arg_v == ARG_BLOCK_END)  lat_v = CTRL_CMD;
      end else if (lat_v == op_mode_r) begin
        if (arg_v == ARG_MODE) begin
          mode_nxt = d_byte;
          lat_v    = CTRL_CMD;
        end
        if (arg_v == ARG_MODE_PAD) lat_v = CTRL_CMD;
      end else if (lat_v == op_res_r) begin
        if (arg_v == ARG_WIDTH)  width_nxt  = d_byte;
        if (arg_v == ARG_HEIGHT) height_nxt = d_byte;
        if (arg_v == ARG_BPP) begin
          bpp_nxt = d_byte;
          lat_v   = CTRL_CMD;
        end
      end else if (lat_v == op_disp_r) begin
        disp_nxt = 1'b1;
        lat_v    = CTRL_CMD;
      end
      latch_nxt = lat_v;
      arg_nxt   = arg_v + 8'd1;
    end
  end

  // Configuration and controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r <= 8'd128;
      op_block_r    <= 8'd1;
      op_mode_r     <= 8'd2;
      op_res_r      <= 8'd3;
      op_disp_r     <= 8'd4;
      latch_r       <= LATCH_ARMED;
      arg_r         <= '0;
      first_col_r   <= '0;
      last_col_r    <= '0;
      col_r         <= '0;
      row_r         <= '0;
      mode_r        <= 8'd1;
      width_r       <= '0;
      height_r      <= '0;
      bpp_r         <= '0;
      disp_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PANEL_WIDTH: panel_width_r <= cfg_wdata;
          CFG_OP_BLOCK:    op_block_r    <= cfg_wdata;
          CFG_OP_MODE:     op_mode_r     <= cfg_wdata;
          CFG_OP_RES:      op_res_r      <= cfg_wdata;
          CFG_OP_DISP_ON:  op_disp_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (func)
          FN_START, FN_STOP: latch_r <= LATCH_ARMED;
          FN_BYTE: begin
            latch_r     <= latch_nxt;
            arg_r       <= arg_nxt;
            first_col_r <= first_col_nxt;
            last_col_r  <= last_col_nxt;
            col_r       <= col_nxt;
            row_r       <= row_nxt;
            mode_r      <= mode_nxt;
            width_r     <= width_nxt;
            height_r    <= height_nxt;
            bpp_r       <= bpp_nxt;
            disp_r      <= disp_nxt;
          end
          default: ;
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (func == FN_READ)                state_nxt = ST_RDCAP;
          else if (func == FN_BYTE && pixel_go) state_nxt = ST_SCAT;
          else                                state_nxt = ST_DONE;
        end
      end
      ST_RDCAP: state_nxt = ST_DONE;
      ST_SCAT:  if (scat_k_r == 3'd7) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_DONE;
      ST_DONE:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    done_load = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = wr_addr_r[MEM_AW-1:0];
    mem_ra    = raddr_ext[MEM_AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
      end
      ST_IDLE:  in_tready = 1'b1;
      ST_SCAT: begin
        mem_ra = scat_addr_r[MEM_AW-1:0];
        mem_we = (scat_k_r != 3'd0) && wr_ok_r;
      end
      ST_FLUSH: mem_we = wr_ok_r;
      ST_DONE:  done_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // Replace one bit of the byte just read
  assign bit_mask = DATA_W'(1) << scat_col_r;
  assign mem_wd   = (state_r == ST_CLEAR) ? '0 :
                    ((mem_rd_r & ~bit_mask) | (wr_bit_r ? bit_mask : '0));

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  // Sequencer and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
    end
  end

  // Scatter walk: read row k while writing back row k-1
  always_ff @(posedge clk) begin
    if (in_acc) begin
      scat_addr_r <= pix_base;
      scat_bits_r <= d_byte;
      scat_col_r  <= col_r[2:0];
      scat_k_r    <= '0;
      rd_ok_r     <= (func == FN_READ) && (raddr_ext < CALC_W'(STORE_SIZE));
      rdata_r     <= '0;
    end
    if (state_r == ST_SCAT) begin
      scat_addr_r <= scat_addr_r + CALC_W'(ROW_BYTES);
      scat_k_r    <= scat_k_r + 3'd1;
      wr_addr_r   <= scat_addr_r;
      wr_ok_r     <= scat_addr_r < CALC_W'(STORE_SIZE);
      wr_bit_r    <= scat_bits_r[scat_k_r];
    end
    if (state_r == ST_RDCAP) rdata_r <= rd_ok_r ? mem_rd_r : '0;
  end

  // Assemble the result word
  always_comb begin
    res_w                 = '0;
    res_w.read_data       = rdata_r;
    res_w.mode_value      = mode_r;
    res_w.display_enabled = disp_r;
    res_w.res_width       = width_r;
    res_w.res_height      = height_r;
    res_w.res_bpp         = bpp_r;
  end

  // Output register: load when free, drop on transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) out_tdata_r <= res_w;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ===== sv/pmdbc_checker.sv =====
// Port-level checks of the page-mode display byte controller and their binding.
`default_nettype none

module pmdbc_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tvalid,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [pmdbc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Reset starts the clearing pass with both channels quiet
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("channel active right after reset");

  // Busy on the cycle after an accepted transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  // Keep padding bits of a result at zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:41] == 7'd0)
    else $error("nonzero padding in result");

endmodule

bind page_mode_display_byte_controller pmdbc_checker u_pmdbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== bench/pmdbc_result_checker.sv =====
// Result checker for the page-mode display byte controller: shadow frame store and compare.
`timescale 1ns / 100ps

module pmdbc_result_checker
  import pmdbc_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [DATA_W-1:0]      cfg_wdata,
  input  wire                    in_tvalid,
  input  wire                    in_tready,
  input  wire  [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], read_addr[17:8]
  input  wire  [FUNC_W-1:0]      in_tuser,   // func[1:0]
  input  wire                    out_tvalid,
  input  wire                    out_tready,
  input  wire  [OUT_TDATA_W-1:0] out_tdata,  // read_data, mode_value, display_enabled,
                                             // res_width, res_height, res_bpp
  output int                     n_errors,
  output int                     n_pending,
  output int                     n_results
);

  localparam int ROW_BYTES   = 16;
  localparam int ROWS        = 64;
  localparam int STORE_BYTES = ROW_BYTES * ROWS;
  localparam int MAX_SHOWN   = 10;

  // Register shadows
  logic [DATA_W-1:0] panel_lim;
  logic [DATA_W-1:0] op_window;
  logic [DATA_W-1:0] op_mode;
  logic [DATA_W-1:0] op_res;
  logic [DATA_W-1:0] op_power;

  // Predicted controller state
  logic [DATA_W-1:0] pix_mem [STORE_BYTES];
  logic [DATA_W-1:0] ctl_byte;
  logic [DATA_W-1:0] arg_pos;
  logic [DATA_W-1:0] win_lo;
  logic [DATA_W-1:0] win_hi;
  logic [DATA_W-1:0] cur_col;
  logic [DATA_W-1:0] cur_row;
  logic [DATA_W-1:0] mode_q;
  logic [DATA_W-1:0] width_q;
  logic [DATA_W-1:0] height_q;
  logic [DATA_W-1:0] bpp_q;
  logic              disp_on;

  result_t pending_results [$];

  // Clamp a column argument to the last pixel of the panel
  function automatic logic [DATA_W-1:0] clamp_col(input logic [DATA_W-1:0] v);
    if (v >= panel_lim) return panel_lim - 8'd1;
    return v;
  endfunction

  // Spread one pixel column over eight rows, skip rows past the store, advance the cursor
  task automatic paint_column(input logic [DATA_W-1:0] bits);
    int                addr;
    logic [DATA_W-1:0] mask;
    addr = int'(cur_col >> 3) + int'(cur_row) * ROW_BYTES;
    mask = 8'h01 << cur_col[2:0];
    for (int k = 0; k < 8; k++) begin
      if (addr < STORE_BYTES) begin
        if (bits[k]) pix_mem[addr] = pix_mem[addr] | mask;
        else         pix_mem[addr] = pix_mem[addr] & ~mask;
      end
      addr += ROW_BYTES;
    end
    cur_col = cur_col + 8'd1;
    if (cur_col > win_hi) begin
      cur_col = win_lo;
      cur_row = cur_row + 8'd8;
    end
  endtask

  // Handle one host byte: control byte, pixel column, command or argument
  task automatic absorb_host_byte(input logic [DATA_W-1:0] d);
    if (ctl_byte == LATCH_ARMED) begin
      ctl_byte = d;
    end else if (ctl_byte == CTRL_DATA) begin
      paint_column(d);
    end else begin
      if (ctl_byte == CTRL_CMD) begin
        ctl_byte = d;
        arg_pos  = 8'd0;
      end
      // first matching opcode wins
      if (ctl_byte == op_window) begin
        if (arg_pos == ARG_FIRST_COL) begin
          win_lo  = clamp_col(d);
          cur_col = win_lo;
        end
        if (arg_pos == ARG_LAST_COL) win_hi = clamp_col(d);
        if (arg_pos == ARG_START_PAGE) cur_row = {d[4:0], 3'b000};
        if (arg_pos == ARG_BLOCK_END) ctl_byte = CTRL_CMD;
      end else if (ctl_byte == op_mode) begin
        if (arg_pos == ARG_MODE) begin
          mode_q   = d;
          ctl_byte = CTRL_CMD;
        end
        if (arg_pos == ARG_MODE_PAD) ctl_byte = CTRL_CMD;
      end else if (ctl_byte == op_res) begin
        if (arg_pos == ARG_WIDTH) width_q = d;
        if (arg_pos == ARG_HEIGHT) height_q = d;
        if (arg_pos == ARG_BPP) begin
          bpp_q    = d;
          ctl_byte = CTRL_CMD;
        end
      end else if (ctl_byte == op_power) begin
        disp_on  = 1'b1;
        ctl_byte = CTRL_CMD;
      end
      arg_pos = arg_pos + 8'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t           got;
    result_t           want;
    func_t             fn;
    logic [RADDR_W-1:0] ra;
    if (!rst_n) begin
      panel_lim = 8'd128;
      op_window = 8'd1;
      op_mode   = 8'd2;
      op_res    = 8'd3;
      op_power  = 8'd4;
      for (int i = 0; i < STORE_BYTES; i++) pix_mem[i] = '0;
      ctl_byte  = LATCH_ARMED;
      arg_pos   = '0;
      win_lo    = '0;
      win_hi    = '0;
      cur_col   = '0;
      cur_row   = '0;
      mode_q    = 8'd1;
      width_q   = '0;
      height_q  = '0;
      bpp_q     = '0;
      disp_on   = 1'b0;
      pending_results.delete();
      n_errors  = 0;
      n_results = 0;
    end else begin
      // Compare a finished result with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: result with nothing pending: %h", $time, out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data || got.mode_value !== want.mode_value ||
              got.display_enabled !== want.display_enabled ||
              got.res_width !== want.res_width || got.res_height !== want.res_height ||
              got.res_bpp !== want.res_bpp) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN) begin
              $display("%0t: result %0d expected rd=%h mode=%h disp=%b w=%h h=%h bpp=%h",
                       $time, n_results, want.read_data, want.mode_value,
                       want.display_enabled, want.res_width, want.res_height, want.res_bpp);
              $display("%0t: result %0d actual   rd=%h mode=%h disp=%b w=%h h=%h bpp=%h",
                       $time, n_results, got.read_data, got.mode_value,
                       got.display_enabled, got.res_width, got.res_height, got.res_bpp);
            end
          end
        end
      end

      // Track register writes; spare indexes are ignored
      if (cfg_we) begin
        case (cfg_index)
          CFG_PANEL_WIDTH: panel_lim = cfg_wdata;
          CFG_OP_BLOCK:    op_window = cfg_wdata;
          CFG_OP_MODE:     op_mode   = cfg_wdata;
          CFG_OP_RES:      op_res    = cfg_wdata;
          CFG_OP_DISP_ON:  op_power  = cfg_wdata;
          default: ;
        endcase
      end

      // Predict the result of each accepted transaction
      if (in_tvalid && in_tready) begin
        fn   = func_t'(in_tuser);
        ra   = in_tdata[DATA_W +: RADDR_W];
        want = '0;
        case (fn)
          FN_START, FN_STOP: ctl_byte = LATCH_ARMED;
          FN_BYTE:           absorb_host_byte(in_tdata[DATA_W-1:0]);
          default: begin
            if (int'(ra) < STORE_BYTES) want.read_data = pix_mem[ra];
          end
        endcase
        want.mode_value      = mode_q;
        want.display_enabled = disp_on;
        want.res_width       = width_q;
        want.res_height      = height_q;
        want.res_bpp         = bpp_q;
        pending_results.push_back(want);
      end
    end
    n_pending = pending_results.size();
  end

endmodule

// ===== bench/tb_page_mode_display_byte_controller.sv =====
// Testbench top for the page-mode display byte controller: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_page_mode_display_byte_controller;
  import pmdbc_pkg::*;

  localparam int                 IN_PAD_W          = IN_TDATA_W - RADDR_W - DATA_W;
  localparam int                 TRAFFIC_PER_PHASE = 320;
  localparam int                 TAIL_CYCLES       = 40;
  localparam int                 CYCLE_LIMIT       = 250000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI    = 3'd7;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_PANEL_WIDTH;
  logic [DATA_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [FUNC_W-1:0]      in_tuser  = FN_START;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int n_errors;
  int n_pending;
  int n_results;
  int n_cycles   = 0;
  int n_sent     = 0;
  int n_reads    = 0;
  int n_pixels   = 0;
  int n_settings = 0;
  int stall_left = 0;

  // Pacing controls: quiet disables all idling, calm flags give idle-free stretches
  logic quiet    = 1'b0;
  logic in_calm  = 1'b0;
  logic out_calm = 1'b0;

  // Stimulus-side copy of the register settings
  logic [DATA_W-1:0] sh_pw;
  logic [DATA_W-1:0] sh_op_window;
  logic [DATA_W-1:0] sh_op_mode;
  logic [DATA_W-1:0] sh_op_res;
  logic [DATA_W-1:0] sh_op_power;

  page_mode_display_byte_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pmdbc_result_checker u_result_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .n_errors   (n_errors),
    .n_pending  (n_pending),
    .n_results  (n_results)
  );

  always #2 clk = ~clk;

  // Stall the result channel in short random bursts
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (!quiet && !out_calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_tready <= (stall_left == 0);
  end

  // Abort a hung run
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("tb_page_mode_display_byte_controller: done, errors");
      $finish;
    end
  end

  // Random byte and random read address
  function automatic logic [DATA_W-1:0] rnd_byte();
    return DATA_W'($urandom);
  endfunction

  function automatic logic [RADDR_W-1:0] rnd_addr();
    return RADDR_W'($urandom);
  endfunction

  // Offer one transaction, with an optional idle burst first, and hold it until taken
  task automatic push_item(input func_t f, input logic [DATA_W-1:0] d,
                           input logic [RADDR_W-1:0] a);
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    if (!quiet && !in_calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = {{IN_PAD_W{1'b0}}, a, d};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    n_sent++;
    if (f == FN_READ) n_reads++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    in_tvalid = 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  // Put one register value on the write port for a cycle
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  // Write all registers, plus junk to the unused indexes
  task automatic apply_settings(input logic [DATA_W-1:0] pw, input logic [DATA_W-1:0] ow,
                                input logic [DATA_W-1:0] om, input logic [DATA_W-1:0] ors,
                                input logic [DATA_W-1:0] op);
    cfg_we = 1'b1;
    put_reg(CFG_PANEL_WIDTH, pw);
    put_reg(CFG_OP_BLOCK, ow);
    put_reg(CFG_OP_MODE, om);
    put_reg(CFG_OP_RES, ors);
    put_reg(CFG_OP_DISP_ON, op);
    for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++) put_reg(CFG_IDX_W'(i), rnd_byte());
    cfg_we = 1'b0;
    sh_pw        = pw;
    sh_op_window = ow;
    sh_op_mode   = om;
    sh_op_res    = ors;
    sh_op_power  = op;
    n_settings++;
  endtask

  // Column argument: mostly from zero up to the panel width, sometimes anything
  function automatic logic [DATA_W-1:0] pick_col();
    if ($urandom_range(0, 3) == 0) return rnd_byte();
    return DATA_W'($urandom_range(0, sh_pw));
  endfunction

  function automatic func_t pick_frame();
    return ($urandom_range(0, 1) != 0) ? FN_START : FN_STOP;
  endfunction

  // Mostly well-formed sessions with random content, some reads and some noise
  task automatic run_traffic(input int n_items);
    int stop_at;
    int r;
    int n;
    int kind;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        // pixel session
        push_item(pick_frame(), rnd_byte(), rnd_addr());
        push_item(FN_BYTE, CTRL_DATA, rnd_addr());
        n = $urandom_range(1, 24);
        repeat (n) push_item(FN_BYTE, rnd_byte(), rnd_addr());
        n_pixels += n;
      end else if (r < 62) begin
        // command session
        push_item(pick_frame(), rnd_byte(), rnd_addr());
        push_item(FN_BYTE, CTRL_CMD, rnd_addr());
        repeat ($urandom_range(1, 4)) begin
          kind = $urandom_range(0, 9);
          if (kind < 4) begin
            push_item(FN_BYTE, sh_op_window, rnd_addr());
            push_item(FN_BYTE, pick_col(), rnd_addr());
            push_item(FN_BYTE, pick_col(), rnd_addr());
            push_item(FN_BYTE, ($urandom_range(0, 3) == 0) ? rnd_byte() :
                      DATA_W'($urandom_range(0, 7)), rnd_addr());
            if ($urandom_range(0, 1) != 0) push_item(FN_BYTE, rnd_byte(), rnd_addr());
          end else if (kind < 6) begin
            push_item(FN_BYTE, sh_op_mode, rnd_addr());
            push_item(FN_BYTE, rnd_byte(), rnd_addr());
            if ($urandom_range(0, 2) == 0) push_item(FN_BYTE, rnd_byte(), rnd_addr());
          end else if (kind < 8) begin
            push_item(FN_BYTE, sh_op_res, rnd_addr());
            repeat (3) push_item(FN_BYTE, rnd_byte(), rnd_addr());
          end else if (kind < 9) begin
            push_item(FN_BYTE, sh_op_power, rnd_addr());
          end else begin
            // unknown opcode and its trailing bytes
            repeat ($urandom_range(1, 3)) push_item(FN_BYTE, rnd_byte(), rnd_addr());
          end
        end
        push_item(pick_frame(), rnd_byte(), rnd_addr());
      end else if (r < 90) begin
        // scan-out reads
        repeat ($urandom_range(1, 8)) push_item(FN_READ, rnd_byte(), rnd_addr());
      end else begin
        // noise
        repeat ($urandom_range(1, 6)) push_item(func_t'($urandom_range(0, 3)), rnd_byte(),
                                                 rnd_addr());
      end
    end
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] shared_op;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset values, panel width at its top
    apply_settings(8'd128, 8'd1, 8'd2, 8'd3, 8'd4);
    push_item(FN_READ, rnd_byte(), 10'd1023);
    // command mode: window clamped to the panel edge, start page 7, then each command
    push_item(FN_BYTE, CTRL_CMD, rnd_addr());
    push_item(FN_BYTE, sh_op_window, rnd_addr());
    push_item(FN_BYTE, 8'hFF, rnd_addr());
    push_item(FN_BYTE, 8'hFF, rnd_addr());
    push_item(FN_BYTE, 8'h07, rnd_addr());
    push_item(FN_BYTE, 8'h00, rnd_addr());
    push_item(FN_BYTE, sh_op_mode, rnd_addr());
    push_item(FN_BYTE, 8'hA5, rnd_addr());
    push_item(FN_BYTE, sh_op_res, rnd_addr());
    push_item(FN_BYTE, 8'hFF, rnd_addr());
    push_item(FN_BYTE, 8'h00, rnd_addr());
    push_item(FN_BYTE, 8'h80, rnd_addr());
    push_item(FN_BYTE, sh_op_power, rnd_addr());
    // unknown opcode swallows the rest of the session
    push_item(FN_BYTE, 8'h77, rnd_addr());
    push_item(FN_STOP, rnd_byte(), rnd_addr());
    // last column of the bottom page, then a column that falls past the store
    push_item(FN_BYTE, CTRL_DATA, rnd_addr());
    push_item(FN_BYTE, 8'hFF, rnd_addr());
    push_item(FN_BYTE, 8'h5A, rnd_addr());
    push_item(FN_READ, rnd_byte(), 10'd911);
    run_traffic(TRAFFIC_PER_PHASE);
    settle();

    // Narrowest panel, top opcode
    apply_settings(8'd1, 8'd254, 8'h80, 8'h10, 8'h20);
    run_traffic(TRAFFIC_PER_PHASE);
    settle();

    // Zero panel width clamps to 0xFF; mode and resolution opcodes alias control codes
    apply_settings(8'd0, 8'h11, CTRL_DATA, LATCH_ARMED, 8'hFE);
    push_item(FN_START, rnd_byte(), rnd_addr());
    push_item(FN_BYTE, CTRL_CMD, rnd_addr());
    push_item(FN_BYTE, sh_op_window, rnd_addr());
    push_item(FN_BYTE, 8'hC8, rnd_addr());
    push_item(FN_BYTE, 8'h05, rnd_addr());
    push_item(FN_BYTE, 8'h02, rnd_addr());
    push_item(FN_STOP, rnd_byte(), rnd_addr());
    // column 255 lands past the end of its row
    push_item(FN_BYTE, CTRL_DATA, rnd_addr());
    push_item(FN_BYTE, 8'hC3, rnd_addr());
    push_item(FN_READ, rnd_byte(), 10'd287);
    run_traffic(TRAFFIC_PER_PHASE);
    settle();

    // Window and mode opcodes collide: the window command wins
    shared_op = DATA_W'($urandom_range(1, 254));
    apply_settings(DATA_W'($urandom_range(1, 128)), shared_op, shared_op, 8'd1,
                   DATA_W'($urandom_range(1, 254)));
    run_traffic(TRAFFIC_PER_PHASE);
    settle();

    // Final stretch at full rate on both sides
    quiet = 1'b1;
    apply_settings(DATA_W'($urandom_range(1, 128)), 8'h21, 8'h22, 8'h23, 8'h24);
    run_traffic(TRAFFIC_PER_PHASE);
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d transactions over %0d register settings: %0d pixel columns, %0d reads",
             n_sent, n_settings, n_pixels, n_reads);
    $display("checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_page_mode_display_byte_controller: done, clean");
    end else begin
      $display("tb_page_mode_display_byte_controller: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pmdbc_pkg.sv
sv/page_mode_display_byte_controller.sv
sv/pmdbc_checker.sv
bench/pmdbc_result_checker.sv
bench/tb_page_mode_display_byte_controller.sv
